// ===== hdl/min_gap_max_range_tracker_core_macros.svh =====
// Assertion macros shared by the span tracker RTL
`ifndef MIN_GAP_MAX_RANGE_TRACKER_CORE_MACROS_SVH
`define MIN_GAP_MAX_RANGE_TRACKER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define MGR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MGR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MGR_ASSERT_SAME(label, ante, cons, msg)
`define MGR_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== hdl/mgr_pkg.sv =====
// Shared constants and types for the span tracker
`timescale 1ns / 1ps
package mgr_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int VAL_W       = 32;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_W       = 7;
    localparam int ADDR_W      = 3;

    localparam logic [ADDR_W-3:0] REG_CAPACITY = '0;

    typedef struct packed {
        logic [VAL_W-1:0] val;
        logic             occ;
        logic             take;
    } link_t;

    typedef struct packed {
        logic             pred_hit;
        logic [VAL_W-1:0] pred_val;
        logic             succ_hit;
        logic [VAL_W-1:0] succ_val;
    } hit_t;

endpackage

// ===== hdl/mgr_in_if.sv =====
// Input channel carrying one offered number per beat
`timescale 1ns / 1ps
interface mgr_in_if;
    logic                    valid;
    logic                    ready;
    logic signed [31:0]      value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

// ===== hdl/mgr_out_if.sv =====
// Result channel carrying the reject flag and both spans per beat
`timescale 1ns / 1ps
interface mgr_out_if;
    logic        valid;
    logic        ready;
    logic        rejected;
    logic        spans_valid;
    logic [31:0] shortest_span;
    logic [31:0] longest_span;

    modport source (output valid, output rejected, output spans_valid,
                    output shortest_span, output longest_span, input ready);
    modport sink (input valid, input rejected, input spans_valid,
                  input shortest_span, input longest_span, output ready);
endinterface

// ===== hdl/mgr_cell.sv =====
// One slot of the sorted insertion chain
`timescale 1ns / 1ps
module mgr_cell
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         commit,
    input  logic [mgr_pkg::VAL_W-1:0]    key,
    input  mgr_pkg::link_t               left,
    output mgr_pkg::link_t               right,
    output mgr_pkg::hit_t                hit
);

    logic                      occ_reg;
    logic [mgr_pkg::VAL_W-1:0] val_reg;
    logic                      take;
    logic                      first;

    assign take  = !occ_reg || (val_reg > key);
    assign first = take && !left.take;

    assign right.val  = val_reg;
    assign right.occ  = occ_reg;
    assign right.take = take;

    assign hit.pred_hit = first && left.occ;
    assign hit.pred_val = (first && left.occ) ? left.val : '0;
    assign hit.succ_hit = first && occ_reg;
    assign hit.succ_val = (first && occ_reg) ? val_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else if (commit && take)
        begin
            occ_reg <= left.take ? left.occ : 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit && take)
        begin
            val_reg <= left.take ? left.val : key;
        end
    end

endmodule

// ===== hdl/min_gap_max_range_tracker_core.sv =====
// Span tracker top level: sorted insertion chain, gap fold and APB register
`timescale 1ns / 1ps
// Keeps up to capacity signed numbers (at most 64) in a chain of sorted cells and
// answers each offered number with a reject flag, the minimum adjacent gap and the
// max-minus-min range. An item passes through ST_SHIFT, in which every cell compares
// the broadcast number and the chain shifts to open its slot, and then ST_GAP, in
// which the gaps to the two new neighbors are folded into the running minimum and the
// result beat is loaded. The next item is taken in ST_GAP as that result beat is
// loaded; a held result stalls the input. The store needs no clearing after reset.
`include "min_gap_max_range_tracker_core_macros.svh"
module min_gap_max_range_tracker_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mgr_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    mgr_in_if.sink                       in_bus,
    mgr_out_if.source                    out_bus
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SHIFT = 3'b010,
        ST_GAP   = 3'b100
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic [mgr_pkg::CAP_W-1:0]    capacity_reg;
    logic [mgr_pkg::CNT_W-1:0]    count_reg;
    logic [mgr_pkg::VAL_W-1:0]    key_reg;
    logic                         ins_reg;
    logic [mgr_pkg::VAL_W-1:0]    gap_reg;
    logic [mgr_pkg::VAL_W-1:0]    gap_next;
    logic [mgr_pkg::VAL_W-1:0]    lo_reg;
    logic [mgr_pkg::VAL_W-1:0]    hi_reg;
    logic                         pred_hit_reg;
    logic [mgr_pkg::VAL_W-1:0]    pred_val_reg;
    logic                         succ_hit_reg;
    logic [mgr_pkg::VAL_W-1:0]    succ_val_reg;
    logic                         out_vld_reg;
    logic                         out_rej_reg;
    logic                         out_spv_reg;
    logic [mgr_pkg::VAL_W-1:0]    out_short_reg;
    logic [mgr_pkg::VAL_W-1:0]    out_long_reg;

    logic                         cfg_sel;
    logic                         can_load;
    logic                         accept;
    logic                         full;
    logic                         commit;
    logic [mgr_pkg::VAL_W-1:0]    in_key;
    logic [mgr_pkg::VAL_W-1:0]    pred_gap;
    logic [mgr_pkg::VAL_W-1:0]    succ_gap;
    logic [mgr_pkg::VAL_W-1:0]    gap_mid;
    logic                         spans_ok;
    logic                         pred_any;
    logic                         succ_any;
    logic [mgr_pkg::VAL_W-1:0]    pred_val;
    logic [mgr_pkg::VAL_W-1:0]    succ_val;
    logic [mgr_pkg::MAX_ENTRIES-1:0] first_vec;

    mgr_pkg::link_t               link [0:mgr_pkg::MAX_ENTRIES];
    mgr_pkg::hit_t                hit  [0:mgr_pkg::MAX_ENTRIES-1];

    // configuration port
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[mgr_pkg::ADDR_W-1:2] == mgr_pkg::REG_CAPACITY);
    assign prdata  = cfg_sel ? 32'(capacity_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && cfg_sel)
        begin
            capacity_reg <= pwdata[mgr_pkg::CAP_W-1:0];
        end
    end

    // handshake and sequencing
    assign can_load     = !out_vld_reg || out_bus.ready;
    assign in_bus.ready = (state_reg == ST_IDLE) || ((state_reg == ST_GAP) && can_load);
    assign accept       = in_bus.valid && in_bus.ready;
    assign commit       = (state_reg == ST_SHIFT) && ins_reg;
    assign in_key       = {~in_bus.value[31], in_bus.value[30:0]};
    assign full         = (32'(count_reg) >= 32'(capacity_reg))
                       || (32'(count_reg) >= 32'(mgr_pkg::MAX_ENTRIES));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                state_next = ST_GAP;
            end
            ST_GAP:
            begin
                if (can_load)
                begin
                    state_next = accept ? ST_SHIFT : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ins_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                ins_reg <= !full;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= in_key;
        end
    end

    // sorted chain
    assign link[0] = '{val: '0, occ: 1'b0, take: 1'b0};

    for (genvar i = 0; i < mgr_pkg::MAX_ENTRIES; i++)
    begin : g_cell
        mgr_cell u_cell
        (
            .clk    (clk),
            .rst_n  (rst_n),
            .commit (commit),
            .key    (key_reg),
            .left   (link[i]),
            .right  (link[i+1]),
            .hit    (hit[i])
        );
        assign first_vec[i] = link[i+1].take && !link[i].take;
    end

    always_comb
    begin
        pred_any = 1'b0;
        succ_any = 1'b0;
        pred_val = '0;
        succ_val = '0;
        for (int i = 0; i < mgr_pkg::MAX_ENTRIES; i++)
        begin
            pred_any = pred_any | hit[i].pred_hit;
            succ_any = succ_any | hit[i].succ_hit;
            pred_val = pred_val | hit[i].pred_val;
            succ_val = succ_val | hit[i].succ_val;
        end
    end

    // capture neighbors, count and extremes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            pred_hit_reg <= 1'b0;
            succ_hit_reg <= 1'b0;
        end
        else if (state_reg == ST_SHIFT)
        begin
            pred_hit_reg <= pred_any && ins_reg;
            succ_hit_reg <= succ_any && ins_reg;
            if (ins_reg)
            begin
                count_reg <= count_reg + mgr_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SHIFT)
        begin
            pred_val_reg <= pred_val;
            succ_val_reg <= succ_val;
        end
        if (commit)
        begin
            if (count_reg == '0)
            begin
                lo_reg <= key_reg;
                hi_reg <= key_reg;
            end
            else
            begin
                if (key_reg < lo_reg)
                begin
                    lo_reg <= key_reg;
                end
                if (key_reg > hi_reg)
                begin
                    hi_reg <= key_reg;
                end
            end
        end
    end

    // fold gaps
    assign pred_gap = key_reg - pred_val_reg;
    assign succ_gap = succ_val_reg - key_reg;
    assign gap_mid  = (pred_hit_reg && (pred_gap < gap_reg)) ? pred_gap : gap_reg;
    assign gap_next = (succ_hit_reg && (succ_gap < gap_mid)) ? succ_gap : gap_mid;
    assign spans_ok = (count_reg >= mgr_pkg::CNT_W'(2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg     <= '1;
            out_vld_reg <= 1'b0;
        end
        else if ((state_reg == ST_GAP) && can_load)
        begin
            gap_reg     <= gap_next;
            out_vld_reg <= 1'b1;
        end
        else if (out_bus.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_GAP) && can_load)
        begin
            out_rej_reg   <= !ins_reg;
            out_spv_reg   <= spans_ok;
            out_short_reg <= spans_ok ? gap_next : '0;
            out_long_reg  <= spans_ok ? (hi_reg - lo_reg) : '0;
        end
    end

    assign out_bus.valid         = out_vld_reg;
    assign out_bus.rejected      = out_rej_reg;
    assign out_bus.spans_valid   = out_spv_reg;
    assign out_bus.shortest_span = out_short_reg;
    assign out_bus.longest_span  = out_long_reg;

    `MGR_ASSERT_SAME(a_count_bound, 1'b1, 32'(count_reg) <= 32'(mgr_pkg::MAX_ENTRIES), "overflow")
    `MGR_ASSERT_SAME(a_one_slot, commit, $onehot(first_vec), "insert slot not unique")
    `MGR_ASSERT_NEXT(a_count_step, commit, count_reg == $past(count_reg) + 7'd1, "count stuck")
    `MGR_ASSERT_NEXT(a_accept_shift, accept, state_reg == ST_SHIFT, "accepted beat not shifted")
    `MGR_ASSERT_SAME(a_lo_hi, count_reg != '0, lo_reg <= hi_reg, "extremes out of order")

endmodule

// ===== dv/tb_min_gap_max_range_tracker_core.sv =====
// Self-checking testbench for the span tracker: directed rows, then random capacity phases
`timescale 1ns / 1ps
module tb_min_gap_max_range_tracker_core;

    localparam logic [mgr_pkg::ADDR_W-3:0] REG_SPARE = 1'b1;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_COUNT = 22;
    localparam int PHASE_ITEMS = 62;
    localparam int DIRECTED_COUNT = 13;

    typedef struct packed {
        logic        rejected;
        logic        spans_valid;
        logic [31:0] shortest_span;
        logic [31:0] longest_span;
    } span_result_t;

    typedef struct packed {
        logic                           cfg_write;
        logic [mgr_pkg::ADDR_W-3:0]     cfg_reg;
        logic [31:0]                    cfg_data;
        logic signed [31:0]             value;
        logic                           typed;
        span_result_t                   want;
    } directed_row_t;

    localparam span_result_t REJECT_EMPTY = '{1'b1, 1'b0, 32'd0, 32'd0};
    localparam span_result_t HELD_ALONE = '{1'b0, 1'b0, 32'd0, 32'd0};
    localparam span_result_t HELD_TRIO = '{1'b1, 1'b1, 32'd300000000, 32'd900000000};

    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{1'b1, mgr_pkg::REG_CAPACITY, 32'd0, 32'sh8000_0000, 1'b1, REJECT_EMPTY},
        '{1'b0, mgr_pkg::REG_CAPACITY, 32'd0, 32'sh7FFF_FFFF, 1'b1, REJECT_EMPTY},
        '{1'b0, mgr_pkg::REG_CAPACITY, 32'd0, 32'sd0, 1'b1, REJECT_EMPTY},
        '{1'b1, REG_SPARE, 32'h7F, -32'sd1, 1'b1, REJECT_EMPTY},
        '{1'b1, mgr_pkg::REG_CAPACITY, 32'd1, 32'sd100000000, 1'b1, HELD_ALONE},
        '{1'b0, mgr_pkg::REG_CAPACITY, 32'd0, -32'sd100000000, 1'b1,
          '{1'b1, 1'b0, 32'd0, 32'd0}},
        '{1'b1, mgr_pkg::REG_CAPACITY, 32'd3, 32'sd400000000, 1'b1,
          '{1'b0, 1'b1, 32'd300000000, 32'd300000000}},
        '{1'b0, mgr_pkg::REG_CAPACITY, 32'd0, -32'sd500000000, 1'b1,
          '{1'b0, 1'b1, 32'd300000000, 32'd900000000}},
        '{1'b0, mgr_pkg::REG_CAPACITY, 32'd0, 32'sd7, 1'b1, HELD_TRIO},
        '{1'b1, mgr_pkg::REG_CAPACITY, 32'd2, 32'sd0, 1'b1, HELD_TRIO},
        '{1'b1, mgr_pkg::REG_CAPACITY, 32'd127, 32'sd250000000, 1'b0, '0},
        '{1'b0, mgr_pkg::REG_CAPACITY, 32'd0, 32'sd1500000000, 1'b0, '0},
        '{1'b0, mgr_pkg::REG_CAPACITY, 32'd0, -32'sd1200000000, 1'b0, '0}
    };

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [mgr_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;

    mgr_in_if  in_bus ();
    mgr_out_if out_bus ();

    min_gap_max_range_tracker_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_bus  (in_bus),
        .out_bus (out_bus)
    );

    logic [mgr_pkg::CAP_W-1:0] capacity_reg = '0;
    int unsigned               held_count = 0;
    logic [31:0]               min_gap = 32'hFFFF_FFFF;
    logic [31:0]               held_keys [mgr_pkg::MAX_ENTRIES];
    span_result_t              pending_spans [$];
    directed_row_t             row_checks [$];
    int                        error_count = 0;
    int                        quiet_cycles = 0;
    int                        gap_pct = 0;
    int                        stall_pct = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // hold keys with the sign bit flipped so unsigned order is signed order
    function automatic span_result_t predict_spans(input logic [31:0] raw);
        logic [31:0]  key;
        int unsigned  limit;
        int unsigned  pos;
        int unsigned  slot;
        span_result_t r;
        key = raw ^ 32'h8000_0000;
        limit = (capacity_reg > mgr_pkg::MAX_ENTRIES) ? mgr_pkg::MAX_ENTRIES : capacity_reg;
        r = '0;
        if (held_count >= limit)
        begin
            r.rejected = 1'b1;
        end
        else
        begin
            pos = 0;
            while (pos < held_count && held_keys[pos] <= key)
                pos++;
            if (pos > 0 && key - held_keys[pos-1] < min_gap)
                min_gap = key - held_keys[pos-1];
            if (pos < held_count && held_keys[pos] - key < min_gap)
                min_gap = held_keys[pos] - key;
            for (slot = held_count; slot > pos; slot--)
                held_keys[slot] = held_keys[slot-1];
            held_keys[pos] = key;
            held_count++;
        end
        if (held_count >= 2)
        begin
            r.spans_valid = 1'b1;
            r.shortest_span = min_gap;
            r.longest_span = held_keys[held_count-1] - held_keys[0];
        end
        return r;
    endfunction

    task automatic check_result;
        span_result_t want;
        if (pending_spans.size() == 0)
        begin
            report_mismatch("result beat with no item outstanding");
        end
        else
        begin
            want = pending_spans.pop_front();
            if (out_bus.rejected !== want.rejected)
                report_mismatch($sformatf("rejected got %0b want %0b",
                                          out_bus.rejected, want.rejected));
            if (out_bus.spans_valid !== want.spans_valid)
                report_mismatch($sformatf("spans_valid got %0b want %0b",
                                          out_bus.spans_valid, want.spans_valid));
            if (out_bus.shortest_span !== want.shortest_span)
                report_mismatch($sformatf("shortest_span got %0d want %0d",
                                          out_bus.shortest_span, want.shortest_span));
            if (out_bus.longest_span !== want.longest_span)
                report_mismatch($sformatf("longest_span got %0d want %0d",
                                          out_bus.longest_span, want.longest_span));
        end
    endtask

    always @(posedge clk)
    begin
        span_result_t  want;
        directed_row_t row;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready
                && paddr[mgr_pkg::ADDR_W-1:2] == mgr_pkg::REG_CAPACITY)
                capacity_reg = pwdata[mgr_pkg::CAP_W-1:0];
            if (out_bus.valid && out_bus.ready)
                check_result();
            if (in_bus.valid && in_bus.ready)
            begin
                want = predict_spans(in_bus.value);
                if (row_checks.size() > 0)
                begin
                    row = row_checks.pop_front();
                    if (row.typed)
                        want = row.want;
                end
                pending_spans = {pending_spans, want};
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_bus.ready <= 1'b0;
        else
            out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("min_gap_max_range_tracker_core regression: fail");
            $finish;
        end
    end

    task automatic apb_transfer(input logic write, input logic [mgr_pkg::ADDR_W-3:0] reg_idx,
                                input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= {reg_idx, 2'b00};
        pwdata <= write ? data : 32'd0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (!write && prdata !== data)
            report_mismatch($sformatf("register read got %0h want %0h", prdata, data));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_for_results;
        do @(posedge clk); while (pending_spans.size() != 0);
    endtask

    task automatic write_register(input logic [mgr_pkg::ADDR_W-3:0] reg_idx,
                                  input logic [31:0] data);
        wait_for_results();
        apb_transfer(1'b1, reg_idx, data);
        if (reg_idx == mgr_pkg::REG_CAPACITY)
            apb_transfer(1'b0, reg_idx,
                         {{(32-mgr_pkg::CAP_W){1'b0}}, data[mgr_pkg::CAP_W-1:0]});
    endtask

    task automatic send_value(input logic signed [31:0] v);
        if (gap_pct > 0 && $urandom_range(99) < gap_pct)
        begin
            in_bus.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < gap_pct);
        end
        in_bus.valid <= 1'b1;
        in_bus.value <= v;
        do @(posedge clk); while (!in_bus.ready);
    endtask

    // near neighbors shrink the gap slowly; the closing phase adds extremes and duplicates
    function automatic logic [31:0] pick_value(input bit closing);
        logic [31:0] v;
        int unsigned sel;
        sel = $urandom_range(99);
        v = $urandom;
        if (closing)
        begin
            if (sel < 20)
                v = 32'h8000_0000;
            else if (sel < 40)
                v = 32'h7FFF_FFFF;
            else if (sel < 70 && held_count > 0)
                v = held_keys[$urandom_range(held_count-1)] ^ 32'h8000_0000;
        end
        else if (sel < 25 && held_count > 0)
        begin
            v = (held_keys[$urandom_range(held_count-1)] ^ 32'h8000_0000)
                + ($urandom >> $urandom_range(4, 28)) + 32'd1;
        end
        return v;
    endfunction

    initial
    begin
        int cap;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_bus.valid = 1'b0;
        in_bus.value = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            if (DIRECTED_ROWS[i].cfg_write)
            begin
                in_bus.valid <= 1'b0;
                write_register(DIRECTED_ROWS[i].cfg_reg, DIRECTED_ROWS[i].cfg_data);
            end
            row_checks = {row_checks, DIRECTED_ROWS[i]};
            send_value(DIRECTED_ROWS[i].value);
        end
        in_bus.valid <= 1'b0;

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                6: cap = 0;
                12: cap = 1;
                20: cap = mgr_pkg::MAX_ENTRIES;
                21: cap = 127;
                default: cap = 8 + 2 * p;
            endcase
            write_register(mgr_pkg::REG_CAPACITY, cap);
            case (p % 4)
                0:
                begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct = 87;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct = 0;
                    stall_pct = 87;
                end
                default:
                begin
                    gap_pct = 18;
                    stall_pct = 18;
                end
            endcase
            repeat (PHASE_ITEMS) send_value(pick_value(p >= 20));
            in_bus.valid <= 1'b0;
        end

        wait_for_results();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("min_gap_max_range_tracker_core regression: pass");
        else
            $display("min_gap_max_range_tracker_core regression: fail");
        $finish;
    end

endmodule
